>>> rtl/core/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and compare helpers of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int PIX_W        = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_W        = 13;   // input row runs up to height + 1
   localparam int OUT_ROW_W    = 12;
   localparam int MAX_HEIGHT   = 4096;
   localparam int RESET_WIDTH  = 512;
   localparam int RESET_HEIGHT = 512;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef logic [PIX_W-1:0] pix_type;

   // one window column: [0] top, [1] middle, [2] bottom
   typedef pix_type [2:0] column_type;

   // window: [0] oldest column .. [2] newest column
   typedef column_type [2:0] window_type;

   typedef struct packed {
      logic first_col;
      logic row_ge1;
      logic row_ge2;
      logic due;
      logic eor;
      logic eof;
   } op_ctrl_type;

   typedef struct packed {
      logic eor;
      logic eof;
   } res_flags_type;

   typedef struct packed {
      pix_type lo;
      pix_type mid;
      pix_type hi;
   } sorted3_type;

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max3(input pix_type a, input pix_type b, input pix_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic pix_type min3(input pix_type a, input pix_type b, input pix_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic sorted3_type sort3(input column_type col);
      pix_type     x0;
      pix_type     x1;
      pix_type     x2;
      pix_type     t;
      sorted3_type s;
      x0 = col[0];
      x1 = col[1];
      x2 = col[2];
      if (x0 > x1) begin
         t  = x0;
         x0 = x1;
         x1 = t;
      end
      if (x1 > x2) begin
         t  = x1;
         x1 = x2;
         x2 = t;
      end
      if (x0 > x1) begin
         t  = x0;
         x0 = x1;
         x1 = t;
      end
      s.lo  = x0;
      s.mid = x1;
      s.hi  = x2;
      return s;
   endfunction

endpackage

>>> rtl/core/median_filter_3x3_zero_pad.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_zero_pad
// Streaming 3x3 median filter over 8-bit grey frames, zero-padded borders.
//
// Pixels go in raster order, one item per clock sustained unless stalled.
// Each output is the median of the 3x3 neighbourhood of a pixel position
// (outside the frame counts as 0) and appears once the pixel one row and one
// column further on has gone in; after the last pixel of a frame, flush items
// (req_type = 1) push out the pending outputs one each, the last flagged
// end_of_frame. A flush during a frame is swallowed; a pixel sent while
// outputs are still pending counts as a flush. Every item costs one
// line-buffer read/write slot, so the rate is one item per cycle when not
// stalled; the one exception is the first flush of a one-row frame, which
// occupies two slots. Results pass the queue, the line-buffer stage, the
// window register and the three-stage median network. Writing image_width or
// image_height restarts the frame; write them only while the block is idle.
// Line buffers are two MAX_WIDTH x 8 RAMs and need no clearing after reset.
// ----------------------------------------------------------------------------
module median_filter_3x3_zero_pad #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mf3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]  csr_data,
   // input items
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [7:0]                      req_pixel,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_median,
   output logic                            rsp_end_of_row,
   output logic                            rsp_end_of_frame
);
   import mf3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic             en;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   op_ctrl_type      push_ctrl;
   logic [COL_W-1:0] push_col;
   pix_type          push_pix;
   op_ctrl_type      head_ctrl;
   logic [COL_W-1:0] head_col;
   pix_type          head_pix;
   logic             nine_valid;
   window_type       nine;
   res_flags_type    nine_flags;
   res_flags_type    rsp_flags;

   // registers are always writable
   assign csr_ready = 1'b1;

   // back end moves whenever the result register is free or being drained
   assign en = !rsp_valid || rsp_ready;

   // front: geometry, counters, classification of each item
   mf3_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_pixel (req_pixel),
      .q_full    (q_full),
      .push      (q_push),
      .push_ctrl (push_ctrl),
      .push_col  (push_col),
      .push_pix  (push_pix)
   );

   // decouples front from a stalled back end
   mf3_queue #(
      .COL_W (COL_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_ctrl (push_ctrl),
      .push_col  (push_col),
      .push_pix  (push_pix),
      .pop       (q_pop),
      .head_ctrl (head_ctrl),
      .head_col  (head_col),
      .head_pix  (head_pix),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: line buffers and sliding window
   mf3_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (!q_empty),
      .in_ctrl    (head_ctrl),
      .in_col     (head_col),
      .in_pix     (head_pix),
      .pop        (q_pop),
      .nine_valid (nine_valid),
      .nine       (nine),
      .nine_flags (nine_flags)
   );

   // median network; its last stage is the result register
   mf3_median u_median (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (nine_valid),
      .in_win     (nine),
      .in_flags   (nine_flags),
      .out_valid  (rsp_valid),
      .out_median (rsp_median),
      .out_flags  (rsp_flags)
   );

   assign rsp_end_of_row   = rsp_flags.eor;
   assign rsp_end_of_frame = rsp_flags.eof;

   // queue never written while full
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue overflow");

   // queue never read while empty
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("queue underflow");

   // the last pixel of a frame is also the last of its row
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_end_of_frame |-> rsp_end_of_row)
      else $error("end of frame without end of row");

endmodule

>>> rtl/core/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-write, single-read RAM, registered read (old data on clash).
// ----------------------------------------------------------------------------
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front
// Frame geometry registers, position counters and item classification.
// ----------------------------------------------------------------------------
module mf3_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [mf3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  mf3_pkg::pix_type                 req_pixel,
   input  logic                             q_full,
   output logic                             push,
   output mf3_pkg::op_ctrl_type             push_ctrl,
   output logic [$clog2(MAX_WIDTH)-1:0]     push_col,
   output mf3_pkg::pix_type                 push_pix
);
   import mf3_pkg::*;

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int EW          = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W       = (EW > WIDTH_REG_W) ? EW : WIDTH_REG_W;
   localparam int RESET_EFF_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

   logic [EW-1:0]           width_ff,   width_in;
   logic [HEIGHT_REG_W-1:0] height_ff,  height_in;
   logic [COL_W-1:0]        in_col_ff,  in_col_in;
   logic [ROW_W-1:0]        in_row_ff,  in_row_in;
   logic [COL_W-1:0]        out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0]    out_row_ff, out_row_in;
   logic                    pend_ff,    pend_in;

   logic [CMP_W-1:0]        wr_width;
   logic [EW-1:0]           width_new;
   logic [HEIGHT_REG_W-1:0] height_new;
   logic                    restart;
   logic                    take;
   logic                    in_frame;
   logic                    row_ge1;
   logic                    row_ge2;
   logic                    due;
   logic                    col_last;
   logic                    eor;
   logic                    eof;

   // clamp written geometry once, at write time
   always_comb begin
      wr_width = CMP_W'(csr_data[WIDTH_REG_W-1:0]);
      if (wr_width == '0) begin
         width_new = EW'(1);
      end else if (wr_width > CMP_W'(MAX_WIDTH)) begin
         width_new = EW'(MAX_WIDTH);
      end else begin
         width_new = wr_width[EW-1:0];
      end
      if (csr_data == '0) begin
         height_new = HEIGHT_REG_W'(1);
      end else if (csr_data > CSR_DATA_W'(MAX_HEIGHT)) begin
         height_new = HEIGHT_REG_W'(MAX_HEIGHT);
      end else begin
         height_new = csr_data;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = width_new;
               restart  = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = height_new;
               restart   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // classification
   assign in_frame  = in_row_ff < height_ff;
   assign req_ready = !pend_ff && !q_full;
   assign take      = req_valid && req_ready;
   assign push      = pend_ff ? !q_full : (take && !(in_frame && req_type == REQ_FLUSH));
   assign push_pix  = (take && in_frame) ? req_pixel : '0;
   assign push_col  = in_col_ff;

   assign row_ge1  = in_row_ff != '0;
   assign row_ge2  = in_row_ff > ROW_W'(1);
   assign due      = row_ge2 || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
   assign col_last = EW'(in_col_ff) == width_ff - EW'(1);
   assign eor      = EW'(out_col_ff) == width_ff - EW'(1);
   assign eof      = eor && (ROW_W'(out_row_ff) == height_ff - ROW_W'(1));

   always_comb begin
      push_ctrl.first_col = in_col_ff == '0;
      push_ctrl.row_ge1   = row_ge1;
      push_ctrl.row_ge2   = row_ge2;
      push_ctrl.due       = due;
      push_ctrl.eor       = due && eor;
      push_ctrl.eof       = due && eof;
   end

   // position update
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (pend_ff) begin
         pend_in = q_full;
      end else begin
         // one-row frame: first flush lands on a position with no result
         pend_in = take && !in_frame && !due;
      end
      if (push) begin
         if (col_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (due) begin
            if (eof) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (eor) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OUT_ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pend_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= EW'(RESET_EFF_W);
         height_ff  <= HEIGHT_REG_W'(RESET_HEIGHT);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
      end
   end

endmodule

>>> rtl/core/mf3_queue.sv
// ----------------------------------------------------------------------------
// mf3_queue
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module mf3_queue #(
   parameter int COL_W = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mf3_pkg::op_ctrl_type push_ctrl,
   input  logic [COL_W-1:0]     push_col,
   input  mf3_pkg::pix_type     push_pix,
   input  logic                 pop,
   output mf3_pkg::op_ctrl_type head_ctrl,
   output logic [COL_W-1:0]     head_col,
   output mf3_pkg::pix_type     head_pix,
   output logic                 full,
   output logic                 empty
);
   import mf3_pkg::*;

   op_ctrl_type              ctrl_ff [QUEUE_DEPTH];
   logic [COL_W-1:0]         col_ff  [QUEUE_DEPTH];
   pix_type                  pix_ff  [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff,  count_in;

   assign full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_ctrl = ctrl_ff[rd_ptr_ff];
   assign head_col  = col_ff[rd_ptr_ff];
   assign head_pix  = pix_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctrl_ff[wr_ptr_ff] <= push_ctrl;
         col_ff[wr_ptr_ff]  <= push_col;
         pix_ff[wr_ptr_ff]  <= push_pix;
      end
   end

endmodule

>>> rtl/core/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back
// Line buffers and 3x3 window; hands nine values to the median network.
// ----------------------------------------------------------------------------
module mf3_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  mf3_pkg::op_ctrl_type           in_ctrl,
   input  logic [$clog2(MAX_WIDTH)-1:0]   in_col,
   input  mf3_pkg::pix_type               in_pix,
   output logic                           pop,
   output logic                           nine_valid,
   output mf3_pkg::window_type            nine,
   output mf3_pkg::res_flags_type         nine_flags
);
   import mf3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic              b_valid_ff;
   op_ctrl_type       b_ctrl_ff;
   logic [COL_W-1:0]  b_col_ff;
   pix_type           b_pix_ff;
   logic              fwd_hit_ff, fwd_hit_in;
   pix_type           fwd_data_ff;
   window_type        win_ff, win_in;
   logic              nine_valid_ff;
   window_type        nine_ff, nine_in;
   res_flags_type     nine_flags_ff;

   pix_type           above_rd;
   pix_type           two_above_rd;
   pix_type           top;
   pix_type           mid;
   column_type        new_col;
   logic              b_go;

   assign pop  = en && in_valid;
   assign b_go = en && b_valid_ff;

   // line above: written with the new pixel as it is read (old data returned)
   mf3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (pop),
      .wr_addr (in_col),
      .wr_data (in_pix),
      .rd_en   (pop),
      .rd_addr (in_col),
      .rd_data (above_rd)
   );

   // line two above: takes the old line-above value one stage later
   mf3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_two_above (
      .clock   (clock),
      .wr_en   (b_go),
      .wr_addr (b_col_ff),
      .wr_data (above_rd),
      .rd_en   (pop),
      .rd_addr (in_col),
      .rd_data (two_above_rd)
   );

   // same column read while the stage ahead writes it (one-pixel rows)
   assign fwd_hit_in = pop && b_valid_ff && (b_col_ff == in_col);

   always_comb begin
      top        = b_ctrl_ff.row_ge2 ? (fwd_hit_ff ? fwd_data_ff : two_above_rd) : '0;
      mid        = b_ctrl_ff.row_ge1 ? above_rd : '0;
      new_col[0] = top;
      new_col[1] = mid;
      new_col[2] = b_pix_ff;
      if (b_ctrl_ff.first_col) begin
         // result of last row end: right column padded with zero
         nine_in[0] = win_ff[1];
         nine_in[1] = win_ff[2];
         nine_in[2] = '0;
         win_in[0]  = '0;
         win_in[1]  = '0;
         win_in[2]  = new_col;
      end else begin
         win_in[0]  = win_ff[1];
         win_in[1]  = win_ff[2];
         win_in[2]  = new_col;
         nine_in    = win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         nine_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff    <= pop;
         nine_valid_ff <= b_valid_ff && b_ctrl_ff.due;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ctrl_ff           <= in_ctrl;
         b_col_ff            <= in_col;
         b_pix_ff            <= in_pix;
         fwd_hit_ff          <= fwd_hit_in;
         fwd_data_ff         <= above_rd;
         nine_ff             <= nine_in;
         nine_flags_ff.eor   <= b_ctrl_ff.eor;
         nine_flags_ff.eof   <= b_ctrl_ff.eof;
      end
      if (b_go) begin
         win_ff <= win_in;
      end
   end

   assign nine_valid = nine_valid_ff;
   assign nine       = nine_ff;
   assign nine_flags = nine_flags_ff;

endmodule

>>> rtl/core/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median-of-nine network: sort columns, diagonal, final median.
// ----------------------------------------------------------------------------
module mf3_median (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  mf3_pkg::window_type    in_win,
   input  mf3_pkg::res_flags_type in_flags,
   output logic                   out_valid,
   output mf3_pkg::pix_type       out_median,
   output mf3_pkg::res_flags_type out_flags
);
   import mf3_pkg::*;

   logic          s1_valid_ff;
   sorted3_type   s1_ff [3];
   res_flags_type s1_flags_ff;
   logic          s2_valid_ff;
   pix_type       s2_lo_ff;
   pix_type       s2_mid_ff;
   pix_type       s2_hi_ff;
   res_flags_type s2_flags_ff;
   logic          out_valid_ff;
   pix_type       out_median_ff;
   res_flags_type out_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_ff[i] <= sort3(in_win[i]);
         end
         s1_flags_ff   <= in_flags;
         s2_lo_ff      <= max3(s1_ff[0].lo,  s1_ff[1].lo,  s1_ff[2].lo);
         s2_mid_ff     <= med3(s1_ff[0].mid, s1_ff[1].mid, s1_ff[2].mid);
         s2_hi_ff      <= min3(s1_ff[0].hi,  s1_ff[1].hi,  s1_ff[2].hi);
         s2_flags_ff   <= s1_flags_ff;
         out_median_ff <= med3(s2_lo_ff, s2_mid_ff, s2_hi_ff);
         out_flags_ff  <= s2_flags_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_median = out_median_ff;
   assign out_flags  = out_flags_ff;

endmodule
